// ===== src/partition_fit_allocator_core_assert.svh =====
// Assertion macros for the partition fit allocator.
`ifndef PARTITION_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define PARTITION_FIT_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define PFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("partition fit allocator: check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define PFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("partition fit allocator: check failed");

`endif

// ===== src/pfa_pkg.sv =====
// Shared types and constants of the partition fit allocator.
`default_nettype none

package pfa_pkg;

  localparam int unsigned REQ_W       = 2;
  localparam int unsigned AMT_W       = 16;
  localparam int unsigned PIDX_W      = 4;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned OFS_W       = 20;
  localparam int unsigned LEFT_W      = 16;
  localparam int unsigned POL_W       = 2;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned UPC_W       = 4;

  localparam int unsigned AMT_LSB  = 0;
  localparam int unsigned USED_LSB = 16;
  localparam int unsigned PIDX_LSB = 32;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

  localparam logic [POL_W-1:0] POL_BEST  = 2'd0;
  localparam logic [POL_W-1:0] POL_FIRST = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_FIT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD_IDX = 2'd3;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_ACCEPT,
    ACT_BAD_REQ,
    ACT_LOAD,
    ACT_FREE_CHK,
    ACT_FREE_RD,
    ACT_FREE_WR,
    ACT_SCAN_INIT,
    ACT_SCAN_RD,
    ACT_SCAN_EVAL,
    ACT_PICK_RD,
    ACT_ALLOC_WR,
    ACT_NO_FIT,
    ACT_POST
  } act_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NEVER,
    C_NO_IN,
    C_REQ_LOAD,
    C_REQ_ALLOC,
    C_REQ_FREE,
    C_EMPTY,
    C_BAD_IDX,
    C_SCAN_MORE,
    C_NOT_FOUND,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    act_e             act;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic no_in;
    logic req_load;
    logic req_alloc;
    logic req_free;
    logic empty;
    logic bad_idx;
    logic scan_more;
    logic not_found;
    logic out_busy;
  } flags_t;

endpackage

`default_nettype wire

// ===== src/partition_fit_allocator_core.sv =====
// Partition fit allocator: partition table with best, first and worst fit allocation.
//
// One request at a time; a load, free, allocate or unknown request each yields one
// result beat. An allocate scans the table entries, one read and compared per cycle
// through the single read port of the partition memory (all loaded entries, fewer
// under first fit once a fit is found; none when the table is empty or the policy
// is unknown). The result then sits in the output register while the sink stalls.
// A new request is taken the cycle after the result is posted. No clearing pass
// after reset.
`default_nettype none

module partition_fit_allocator_core #(
  parameter int unsigned MAX_PARTS = 16,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pfa_pkg::POL_W-1:0]          cfg_data_i,     // fit_policy
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // amount[15:0], used_amount[31:16], part_index[35:32]
  input  logic [pfa_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input  logic [pfa_pkg::REQ_W-1:0]          s_axis_tuser_i, // req_type
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // chosen_index[3:0], chosen_offset[23:4], space_left[39:24]
  output logic [pfa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic [pfa_pkg::STAT_W-1:0]         m_axis_tuser_o  // status
);

  `include "partition_fit_allocator_core_assert.svh"

  localparam int unsigned SW = (SIZE_BITS < pfa_pkg::AMT_W) ? SIZE_BITS : pfa_pkg::AMT_W;
  localparam int unsigned IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int unsigned CW = $clog2(MAX_PARTS + 1);

  typedef struct packed {
    logic [pfa_pkg::OFS_W-1:0] start;
    logic [SW-1:0]             used;
    logic [SW-1:0]             size;
  } entry_t;

  pfa_pkg::act_e   act;
  pfa_pkg::flags_t flags;

  pfa_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .act_o  (act)
  );

  // partition table
  entry_t          mem [MAX_PARTS];
  entry_t          rd_q;
  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  entry_t          mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // control state
  logic [CW-1:0]                  count_q, count_d;
  logic [pfa_pkg::OFS_W-1:0]      next_start_q, next_start_d;
  logic [pfa_pkg::POL_W-1:0]      pol_q, pol_d;
  logic                           found_q, found_d;
  logic                           out_valid_q, out_valid_d;

  // payload
  logic [pfa_pkg::REQ_W-1:0]      req_q, req_d;
  logic [SW-1:0]                  amt_q, amt_d;
  logic [SW-1:0]                  used_in_q, used_in_d;
  logic [pfa_pkg::PIDX_W-1:0]     pidx_q, pidx_d;
  logic [IW-1:0]                  eidx_q, eidx_d;
  logic [IW-1:0]                  pick_q, pick_d;
  logic [SW-1:0]                  pick_free_q, pick_free_d;
  logic [pfa_pkg::STAT_W-1:0]     res_stat_q, res_stat_d;
  logic [IW-1:0]                  res_idx_q, res_idx_d;
  logic [pfa_pkg::OFS_W-1:0]      res_ofs_q, res_ofs_d;
  logic [SW-1:0]                  res_left_q, res_left_d;
  logic [pfa_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic [pfa_pkg::STAT_W-1:0]     out_stat_q, out_stat_d;

  logic                           in_fire, out_busy;
  logic [SW-1:0]                  fr;
  logic                           fits, take, refused;
  logic [IW+pfa_pkg::PIDX_W-1:0]  pidx_ext;
  logic [IW-1:0]                  pidx_addr;
  logic [IW+pfa_pkg::IDX_W-1:0]   idx_ext;
  logic [SW+pfa_pkg::LEFT_W-1:0]  left_ext;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (act == pfa_pkg::ACT_ACCEPT);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_busy        = out_valid_q && !m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_stat_q;

  assign pidx_ext  = {{IW{1'b0}}, pidx_q};
  assign pidx_addr = pidx_ext[IW-1:0];
  assign idx_ext   = {{pfa_pkg::IDX_W{1'b0}}, res_idx_q};
  assign left_ext  = {{pfa_pkg::LEFT_W{1'b0}}, res_left_q};

  assign fr      = rd_q.size - rd_q.used;
  assign fits    = (fr >= amt_q);
  assign take    = fits && (!found_q ||
                            ((pol_q == pfa_pkg::POL_BEST)  && (pick_free_q >= fr)) ||
                            ((pol_q == pfa_pkg::POL_WORST) && (pick_free_q <= fr)));
  assign refused = (used_in_q > amt_q) || (32'(count_q) >= MAX_PARTS);

  always_comb begin
    flags.no_in     = !in_fire;
    flags.req_load  = (req_q == pfa_pkg::REQ_LOAD);
    flags.req_alloc = (req_q == pfa_pkg::REQ_ALLOC);
    flags.req_free  = (req_q == pfa_pkg::REQ_FREE);
    flags.empty     = (count_q == '0) ||
                      !((pol_q == pfa_pkg::POL_BEST) || (pol_q == pfa_pkg::POL_FIRST) ||
                        (pol_q == pfa_pkg::POL_WORST));
    flags.bad_idx   = (32'(pidx_q) >= 32'(count_q));
    flags.scan_more = ((32'(eidx_q) + 32'd1) < 32'(count_q)) &&
                      !((pol_q == pfa_pkg::POL_FIRST) && (found_q || take));
    flags.not_found = !found_q;
    flags.out_busy  = out_busy;
  end

  always_comb begin
    count_d      = count_q;
    next_start_d = next_start_q;
    pol_d        = pol_q;
    found_d      = found_q;
    out_valid_d  = out_valid_q;
    req_d        = req_q;
    amt_d        = amt_q;
    used_in_d    = used_in_q;
    pidx_d       = pidx_q;
    eidx_d       = eidx_q;
    pick_d       = pick_q;
    pick_free_d  = pick_free_q;
    res_stat_d   = res_stat_q;
    res_idx_d    = res_idx_q;
    res_ofs_d    = res_ofs_q;
    res_left_d   = res_left_q;
    out_data_d   = out_data_q;
    out_stat_d   = out_stat_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = pick_q;
    mem_raddr    = eidx_q;
    mem_wdata    = rd_q;

    if (cfg_valid_i) begin
      pol_d = cfg_data_i;
    end
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (act)
      pfa_pkg::ACT_ACCEPT: begin
        if (in_fire) begin
          req_d     = s_axis_tuser_i;
          amt_d     = s_axis_tdata_i[pfa_pkg::AMT_LSB +: SW];
          used_in_d = s_axis_tdata_i[pfa_pkg::USED_LSB +: SW];
          pidx_d    = s_axis_tdata_i[pfa_pkg::PIDX_LSB +: pfa_pkg::PIDX_W];
        end
      end
      pfa_pkg::ACT_BAD_REQ: begin
        res_stat_d = pfa_pkg::STAT_BAD_IDX;
        res_idx_d  = '0;
        res_ofs_d  = '0;
        res_left_d = '0;
      end
      pfa_pkg::ACT_LOAD: begin
        if (refused) begin
          res_stat_d = pfa_pkg::STAT_REFUSED;
          res_idx_d  = '0;
          res_ofs_d  = '0;
          res_left_d = '0;
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = count_q[IW-1:0];
          mem_wdata    = '{start: next_start_q, used: used_in_q, size: amt_q};
          count_d      = count_q + 1'b1;
          next_start_d = next_start_q + pfa_pkg::OFS_W'(amt_q);
          res_stat_d   = pfa_pkg::STAT_OK;
          res_idx_d    = count_q[IW-1:0];
          res_ofs_d    = next_start_q;
          res_left_d   = amt_q - used_in_q;
        end
      end
      pfa_pkg::ACT_FREE_CHK: begin
        if (flags.bad_idx) begin
          res_stat_d = pfa_pkg::STAT_BAD_IDX;
          res_idx_d  = '0;
          res_ofs_d  = '0;
          res_left_d = '0;
        end
      end
      pfa_pkg::ACT_FREE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = pidx_addr;
      end
      pfa_pkg::ACT_FREE_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = pidx_addr;
        mem_wdata  = '{start: rd_q.start, used: '0, size: rd_q.size};
        res_stat_d = pfa_pkg::STAT_OK;
        res_idx_d  = pidx_addr;
        res_ofs_d  = rd_q.start;
        res_left_d = rd_q.size;
      end
      pfa_pkg::ACT_SCAN_INIT: begin
        found_d = 1'b0;
        eidx_d  = '0;
      end
      pfa_pkg::ACT_SCAN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = eidx_q;
      end
      pfa_pkg::ACT_SCAN_EVAL: begin
        if (take) begin
          found_d     = 1'b1;
          pick_d      = eidx_q;
          pick_free_d = fr;
        end
        mem_re    = 1'b1;
        mem_raddr = eidx_q + 1'b1;
        eidx_d    = eidx_q + 1'b1;
      end
      pfa_pkg::ACT_PICK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = pick_q;
      end
      pfa_pkg::ACT_ALLOC_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = pick_q;
        mem_wdata  = '{start: rd_q.start, used: rd_q.used + amt_q, size: rd_q.size};
        res_stat_d = pfa_pkg::STAT_OK;
        res_idx_d  = pick_q;
        res_ofs_d  = rd_q.start;
        res_left_d = pick_free_q - amt_q;
      end
      pfa_pkg::ACT_NO_FIT: begin
        res_stat_d = pfa_pkg::STAT_NO_FIT;
        res_idx_d  = '0;
        res_ofs_d  = '0;
        res_left_d = '0;
      end
      pfa_pkg::ACT_POST: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_data_d  = {left_ext[pfa_pkg::LEFT_W-1:0], res_ofs_q,
                         idx_ext[pfa_pkg::IDX_W-1:0]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      next_start_q <= '0;
      pol_q        <= pfa_pkg::POL_BEST;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      next_start_q <= next_start_d;
      pol_q        <= pol_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    amt_q       <= amt_d;
    used_in_q   <= used_in_d;
    pidx_q      <= pidx_d;
    eidx_q      <= eidx_d;
    pick_q      <= pick_d;
    pick_free_q <= pick_free_d;
    res_stat_q  <= res_stat_d;
    res_idx_q   <= res_idx_d;
    res_ofs_q   <= res_ofs_d;
    res_left_q  <= res_left_d;
    out_data_q  <= out_data_d;
    out_stat_q  <= out_stat_d;
  end

  `PFA_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_q) <= MAX_PARTS)
  `PFA_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready_o)
  `PFA_ASSERT_NOW(a_scan_in_range, act == pfa_pkg::ACT_SCAN_EVAL, 32'(eidx_q) < 32'(count_q))
  `PFA_ASSERT_NOW(a_error_zero, m_axis_tvalid_o && (m_axis_tuser_o != pfa_pkg::STAT_OK), m_axis_tdata_o == '0)

endmodule

`default_nettype wire

// ===== src/pfa_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
`default_nettype none

module pfa_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pfa_pkg::flags_t flags_i,
  output pfa_pkg::act_e   act_o
);

  localparam logic [pfa_pkg::UPC_W-1:0] U_IDLE      = 'd0;
  localparam logic [pfa_pkg::UPC_W-1:0] U_DISP_A    = 'd1;
  localparam logic [pfa_pkg::UPC_W-1:0] U_DISP_L    = 'd2;
  localparam logic [pfa_pkg::UPC_W-1:0] U_DISP_F    = 'd3;
  localparam logic [pfa_pkg::UPC_W-1:0] U_BAD       = 'd4;
  localparam logic [pfa_pkg::UPC_W-1:0] U_SCAN_INIT = 'd5;
  localparam logic [pfa_pkg::UPC_W-1:0] U_SCAN_RD   = 'd6;
  localparam logic [pfa_pkg::UPC_W-1:0] U_SCAN_EVAL = 'd7;
  localparam logic [pfa_pkg::UPC_W-1:0] U_PICK_RD   = 'd8;
  localparam logic [pfa_pkg::UPC_W-1:0] U_ALLOC_WR  = 'd9;
  localparam logic [pfa_pkg::UPC_W-1:0] U_LOAD      = 'd10;
  localparam logic [pfa_pkg::UPC_W-1:0] U_FREE_CHK  = 'd11;
  localparam logic [pfa_pkg::UPC_W-1:0] U_FREE_RD   = 'd12;
  localparam logic [pfa_pkg::UPC_W-1:0] U_FREE_WR   = 'd13;
  localparam logic [pfa_pkg::UPC_W-1:0] U_NO_FIT    = 'd14;
  localparam logic [pfa_pkg::UPC_W-1:0] U_POST      = 'd15;

  function automatic pfa_pkg::uword_t rom(input logic [pfa_pkg::UPC_W-1:0] a);
    pfa_pkg::uword_t w;
    w = '{act: pfa_pkg::ACT_NOP, cond: pfa_pkg::C_NEVER, target: U_IDLE};
    case (a)
      U_IDLE:      w = '{pfa_pkg::ACT_ACCEPT,    pfa_pkg::C_NO_IN,     U_IDLE};
      U_DISP_A:    w = '{pfa_pkg::ACT_NOP,       pfa_pkg::C_REQ_ALLOC, U_SCAN_INIT};
      U_DISP_L:    w = '{pfa_pkg::ACT_NOP,       pfa_pkg::C_REQ_LOAD,  U_LOAD};
      U_DISP_F:    w = '{pfa_pkg::ACT_NOP,       pfa_pkg::C_REQ_FREE,  U_FREE_CHK};
      U_BAD:       w = '{pfa_pkg::ACT_BAD_REQ,   pfa_pkg::C_ALWAYS,    U_POST};
      U_SCAN_INIT: w = '{pfa_pkg::ACT_SCAN_INIT, pfa_pkg::C_EMPTY,     U_NO_FIT};
      U_SCAN_RD:   w = '{pfa_pkg::ACT_SCAN_RD,   pfa_pkg::C_NEVER,     U_IDLE};
      U_SCAN_EVAL: w = '{pfa_pkg::ACT_SCAN_EVAL, pfa_pkg::C_SCAN_MORE, U_SCAN_EVAL};
      U_PICK_RD:   w = '{pfa_pkg::ACT_PICK_RD,   pfa_pkg::C_NOT_FOUND, U_NO_FIT};
      U_ALLOC_WR:  w = '{pfa_pkg::ACT_ALLOC_WR,  pfa_pkg::C_ALWAYS,    U_POST};
      U_LOAD:      w = '{pfa_pkg::ACT_LOAD,      pfa_pkg::C_ALWAYS,    U_POST};
      U_FREE_CHK:  w = '{pfa_pkg::ACT_FREE_CHK,  pfa_pkg::C_BAD_IDX,   U_POST};
      U_FREE_RD:   w = '{pfa_pkg::ACT_FREE_RD,   pfa_pkg::C_NEVER,     U_IDLE};
      U_FREE_WR:   w = '{pfa_pkg::ACT_FREE_WR,   pfa_pkg::C_ALWAYS,    U_POST};
      U_NO_FIT:    w = '{pfa_pkg::ACT_NO_FIT,    pfa_pkg::C_ALWAYS,    U_POST};
      U_POST:      w = '{pfa_pkg::ACT_POST,      pfa_pkg::C_OUT_BUSY,  U_POST};
      default:     w = '{pfa_pkg::ACT_NOP,       pfa_pkg::C_ALWAYS,    U_IDLE};
    endcase
    return w;
  endfunction

  logic [pfa_pkg::UPC_W-1:0] upc_q, upc_d;
  pfa_pkg::uword_t           uw;
  logic                      jump;

  assign uw    = rom(upc_q);
  assign act_o = uw.act;

  always_comb begin
    case (uw.cond)
      pfa_pkg::C_ALWAYS:    jump = 1'b1;
      pfa_pkg::C_NEVER:     jump = 1'b0;
      pfa_pkg::C_NO_IN:     jump = flags_i.no_in;
      pfa_pkg::C_REQ_LOAD:  jump = flags_i.req_load;
      pfa_pkg::C_REQ_ALLOC: jump = flags_i.req_alloc;
      pfa_pkg::C_REQ_FREE:  jump = flags_i.req_free;
      pfa_pkg::C_EMPTY:     jump = flags_i.empty;
      pfa_pkg::C_BAD_IDX:   jump = flags_i.bad_idx;
      pfa_pkg::C_SCAN_MORE: jump = flags_i.scan_more;
      pfa_pkg::C_NOT_FOUND: jump = flags_i.not_found;
      pfa_pkg::C_OUT_BUSY:  jump = flags_i.out_busy;
      default:              jump = 1'b1;
    endcase
  end

  // post step falls through to idle when the output slot frees
  always_comb begin
    if (jump) begin
      upc_d = uw.target;
    end else if (upc_q == U_POST) begin
      upc_d = U_IDLE;
    end else begin
      upc_d = upc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire
